[hdl/slht_pkg.sv]
// ----------------------------------------------------------------------------
// slht_pkg
// Shared constants, codes and controller/datapath interface types of the
// system call latency histogram table.
// ----------------------------------------------------------------------------
package slht_pkg;

  localparam int THREAD_ENTRIES_DEF = 64;
  localparam int STAT_ENTRIES_DEF   = 64;
  localparam int HIST_BUCKETS_DEF   = 32;

  localparam int NUM_MASKS   = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int THR_RAM_W   = 64 + 64 + 9;
  localparam int STAT_RAM_W  = 64 + 64 + 9 + 64 + 64 + 64;

  localparam logic [1:0] ACT_ENTER = 2'd0;
  localparam logic [1:0] ACT_EXIT  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [3:0] ST_IGNORED    = 4'd0;
  localparam logic [3:0] ST_START_KEPT = 4'd1;
  localparam logic [3:0] ST_START_DROP = 4'd2;
  localparam logic [3:0] ST_NO_START   = 4'd3;
  localparam logic [3:0] ST_UPDATED    = 4'd4;
  localparam logic [3:0] ST_CREATED    = 4'd5;
  localparam logic [3:0] ST_EVICTED    = 4'd6;
  localparam logic [3:0] ST_READ_HIT   = 4'd7;
  localparam logic [3:0] ST_READ_MISS  = 4'd8;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_UPDATE,
    RES_CREATE,
    RES_READ
  } res_kind_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_stat;
    logic       thr_write;
    logic       thr_clear;
    logic       calc_delta;
    logic       log_step;
    logic       sel_hit;
    logic       sel_new;
    logic       stat_update;
    logic       stat_create;
    logic       hist_clear;
    logic       latch_res;
    res_kind_t  res_kind;
    logic [3:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       tracked;
    logic       scan_done;
    logic       hit;
    logic       free_found;
    logic       log_done;
    logic       clr_last;
    logic       rb_in_range;
  } dp_stat_t;

endpackage

[hdl/slht_ram.sv]
// ----------------------------------------------------------------------------
// slht_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slht_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/slht_ctrl.sv]
// ----------------------------------------------------------------------------
// slht_ctrl
// Sequencer for enter, exit and read events; drives the datapath commands.
// ----------------------------------------------------------------------------
module slht_ctrl
  import slht_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output dp_cmd_t  cmd,
  input  dp_stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TSCAN,
    S_LOG,
    S_SSCAN,
    S_HRD,
    S_HWT,
    S_SNEW,
    S_HCLR
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.action)
          ACT_ENTER: begin
            if (st.tracked) begin
              cmd.scan_start = 1'b1;
              state_next     = S_TSCAN;
            end else begin
              cmd.latch_res  = 1'b1;
              cmd.res_status = ST_IGNORED;
              state_next     = S_IDLE;
            end
          end
          ACT_EXIT: begin
            cmd.scan_start = 1'b1;
            state_next     = S_TSCAN;
          end
          ACT_READ: begin
            cmd.scan_start = 1'b1;
            cmd.scan_stat  = 1'b1;
            state_next     = S_SSCAN;
          end
          default: begin
            cmd.latch_res  = 1'b1;
            cmd.res_status = ST_IGNORED;
            state_next     = S_IDLE;
          end
        endcase
      end
      S_TSCAN: begin
        if (st.scan_done) begin
          if (st.action == ACT_ENTER) begin
            cmd.latch_res = 1'b1;
            state_next    = S_IDLE;
            if (st.hit || st.free_found) begin
              cmd.thr_write  = 1'b1;
              cmd.res_status = ST_START_KEPT;
            end else begin
              cmd.res_status = ST_START_DROP;
            end
          end else if (st.hit) begin
            cmd.thr_clear  = 1'b1;
            cmd.calc_delta = 1'b1;
            state_next     = S_LOG;
          end else begin
            cmd.latch_res  = 1'b1;
            cmd.res_status = ST_NO_START;
            state_next     = S_IDLE;
          end
        end
      end
      S_LOG: begin
        if (st.log_done) begin
          cmd.scan_start = 1'b1;
          cmd.scan_stat  = 1'b1;
          state_next     = S_SSCAN;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      S_SSCAN: begin
        if (st.scan_done) begin
          if (st.action == ACT_READ) begin
            if (st.hit && st.rb_in_range) begin
              cmd.sel_hit = 1'b1;
              state_next  = S_HRD;
            end else if (st.hit) begin
              cmd.latch_res  = 1'b1;
              cmd.res_kind   = RES_READ;
              cmd.res_status = ST_READ_HIT;
              state_next     = S_IDLE;
            end else begin
              cmd.latch_res  = 1'b1;
              cmd.res_status = ST_READ_MISS;
              state_next     = S_IDLE;
            end
          end else if (st.hit) begin
            cmd.sel_hit = 1'b1;
            state_next  = S_HRD;
          end else begin
            cmd.sel_new = 1'b1;
            state_next  = S_SNEW;
          end
        end
      end
      S_HRD: begin
        state_next = S_HWT;
      end
      S_HWT: begin
        cmd.latch_res = 1'b1;
        state_next    = S_IDLE;
        if (st.action == ACT_READ) begin
          cmd.res_kind   = RES_READ;
          cmd.res_status = ST_READ_HIT;
        end else begin
          cmd.stat_update = 1'b1;
          cmd.res_kind    = RES_UPDATE;
          cmd.res_status  = ST_UPDATED;
        end
      end
      S_SNEW: begin
        cmd.stat_create = 1'b1;
        state_next      = S_HCLR;
      end
      S_HCLR: begin
        cmd.hist_clear = 1'b1;
        if (st.clr_last) begin
          cmd.latch_res  = 1'b1;
          cmd.res_kind   = RES_CREATE;
          cmd.res_status = st.free_found ? ST_CREATED : ST_EVICTED;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.latch_res;
    end
  end

  assign busy = rst || (state != S_IDLE);

endmodule

[hdl/slht_dp.sv]
// ----------------------------------------------------------------------------
// slht_dp
// Datapath: input latches, table scan engine, log2 unit, tables and results.
// ----------------------------------------------------------------------------
module slht_dp
  import slht_pkg::*;
#(
  parameter int THREAD_ENTRIES = THREAD_ENTRIES_DEF,
  parameter int STAT_ENTRIES   = STAT_ENTRIES_DEF,
  parameter int HIST_BUCKETS   = HIST_BUCKETS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic [1:0]             action,
  input  logic [63:0]            thread_key,
  input  logic [8:0]             call_number,
  input  logic [63:0]            group_key,
  input  logic [63:0]            time_ns,
  input  logic                   failed,
  input  logic [5:0]             read_bucket,
  input  dp_cmd_t                cmd,
  output dp_stat_t               st,
  output logic [3:0]             status,
  output logic [5:0]             bucket,
  output logic [63:0]            call_total,
  output logic [63:0]            error_total,
  output logic [63:0]            latency_total,
  output logic [63:0]            bucket_total
);

  localparam int TIW  = (THREAD_ENTRIES > 1) ? $clog2(THREAD_ENTRIES) : 1;
  localparam int SIW  = (STAT_ENTRIES > 1) ? $clog2(STAT_ENTRIES) : 1;
  localparam int MAXD = (THREAD_ENTRIES > STAT_ENTRIES) ? THREAD_ENTRIES : STAT_ENTRIES;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int HD   = STAT_ENTRIES * HIST_BUCKETS;
  localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;

  // Latched event fields.
  logic [1:0]  in_action;
  logic [63:0] in_thread, in_group, in_time;
  logic [8:0]  in_call;
  logic        in_failed;
  logic [5:0]  in_rbucket;

  logic [63:0] mask [NUM_MASKS];

  // Scan engine.
  logic          scan_on, scan_stat, pend, done_r, hit_r, free_r;
  logic [CW-1:0] cnt, pidx, hit_idx, free_idx;
  logic [SIW-1:0] vict;

  // Recency: every update stamps its entry with a rising sequence number, so
  // the least recently updated entry holds the smallest stamp.
  logic [63:0] upd_seq, best_seq;

  // Captured table contents and exit arithmetic.
  logic [63:0] t_time, s_count, s_err, s_lat, delta, shv;
  logic [8:0]  t_call;
  logic [5:0]  lg, kcnt, lg_clamp;
  logic [SIW-1:0] e_r;

  logic            t_valid [THREAD_ENTRIES];
  logic            s_valid [STAT_ENTRIES];

  logic [THR_RAM_W-1:0]  t_rd, t_wdata;
  logic [STAT_RAM_W-1:0] s_rd, s_wdata;
  logic [63:0]           h_rd, h_wdata;
  logic [TIW-1:0]        t_waddr, pidx_t;
  logic [SIW-1:0]        pidx_s;
  logic [HAW-1:0]        h_addr;
  logic [5:0]            hb, bsel;
  logic [8:0]            key_call;
  logic [CW-1:0]         depth;
  logic                  vld_now, match, t_we, s_we, h_we;

  assign key_call = (in_action == ACT_READ) ? in_call : t_call;
  assign depth    = scan_stat ? CW'(STAT_ENTRIES) : CW'(THREAD_ENTRIES);
  assign pidx_t   = pidx[TIW-1:0];
  assign pidx_s   = pidx[SIW-1:0];
  assign vld_now  = scan_stat ? s_valid[pidx_s] : t_valid[pidx_t];
  assign match    = vld_now && (scan_stat
                    ? (s_rd[264:201] == in_group && s_rd[200:192] == key_call)
                    : (t_rd[136:73] == in_thread));

  assign lg_clamp = (lg > 6'(HIST_BUCKETS - 1)) ? 6'(HIST_BUCKETS - 1) : lg;
  assign bsel     = (in_action == ACT_READ) ? in_rbucket : lg_clamp;
  assign hb       = cmd.hist_clear ? kcnt : bsel;
  assign h_addr   = HAW'(HAW'(e_r) * HAW'(HIST_BUCKETS)) + HAW'(hb);

  always_comb begin
    st.action      = in_action;
    st.tracked     = mask[in_call[8:6]][in_call[5:0]];
    st.scan_done   = done_r;
    st.hit         = hit_r;
    st.free_found  = free_r;
    st.log_done    = (shv[63:1] == 63'd0);
    st.clr_last    = (kcnt == 6'(HIST_BUCKETS - 1));
    st.rb_in_range = ({1'b0, in_rbucket} < 7'(HIST_BUCKETS));
  end

  // Table write ports.
  assign t_we    = cmd.thr_write;
  assign t_waddr = hit_r ? hit_idx[TIW-1:0] : free_idx[TIW-1:0];
  assign t_wdata = {in_thread, in_time, in_call};
  assign s_we    = cmd.stat_update || cmd.stat_create;
  assign s_wdata = cmd.stat_create
                   ? {upd_seq, in_group, key_call, 64'd1, {63'd0, in_failed}, delta}
                   : {upd_seq, in_group, key_call, s_count + 64'd1,
                      s_err + {63'd0, in_failed}, s_lat + delta};
  assign h_we    = cmd.stat_update || cmd.hist_clear;
  assign h_wdata = cmd.hist_clear ? ((kcnt == lg_clamp) ? 64'd1 : 64'd0) : (h_rd + 64'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_action  <= action;
      in_thread  <= thread_key;
      in_call    <= call_number;
      in_group   <= group_key;
      in_time    <= time_ns;
      in_failed  <= failed;
      in_rbucket <= read_bucket;
    end
    if (cmd.calc_delta) begin
      delta <= in_time - t_time;
      shv   <= in_time - t_time;
      lg    <= 6'd0;
    end else if (cmd.log_step) begin
      shv <= shv >> 1;
      lg  <= lg + 6'd1;
    end
    if (cmd.sel_hit) begin
      e_r <= hit_idx[SIW-1:0];
    end else if (cmd.sel_new) begin
      e_r <= free_r ? free_idx[SIW-1:0] : vict;
    end
    if (cmd.stat_create) begin
      kcnt <= 6'd0;
    end else if (cmd.hist_clear) begin
      kcnt <= kcnt + 6'd1;
    end
    if (scan_on && !done_r && pend && match) begin
      if (scan_stat) begin
        s_count <= s_rd[191:128];
        s_err   <= s_rd[127:64];
        s_lat   <= s_rd[63:0];
      end else begin
        t_time <= t_rd[72:9];
        t_call <= t_rd[8:0];
      end
    end
    if (cmd.latch_res) begin
      status        <= cmd.res_status;
      bucket_total  <= 64'd0;
      call_total    <= 64'd0;
      error_total   <= 64'd0;
      latency_total <= 64'd0;
      case (cmd.res_kind)
        RES_UPDATE: begin
          call_total    <= s_count + 64'd1;
          error_total   <= s_err + {63'd0, in_failed};
          latency_total <= s_lat + delta;
          bucket_total  <= h_rd + 64'd1;
        end
        RES_CREATE: begin
          call_total    <= 64'd1;
          error_total   <= {63'd0, in_failed};
          latency_total <= delta;
          bucket_total  <= 64'd1;
        end
        RES_READ: begin
          call_total    <= s_count;
          error_total   <= s_err;
          latency_total <= s_lat;
          bucket_total  <= st.rb_in_range ? h_rd : 64'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result bucket only counts for an exit that found its start record.
  logic res_bucket_en;
  logic [5:0] bucket_q;
  assign res_bucket_en = (cmd.res_kind == RES_UPDATE) || (cmd.res_kind == RES_CREATE);

  always_ff @(posedge clk) begin
    if (cmd.latch_res) begin
      bucket_q <= res_bucket_en ? lg_clamp : 6'd0;
    end
  end

  assign bucket = bucket_q;

  // Control state: masks, valid bits, update sequence and the scan engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < NUM_MASKS; m++) begin
        mask[m] <= 64'd0;
      end
      for (int i = 0; i < THREAD_ENTRIES; i++) begin
        t_valid[i] <= 1'b0;
      end
      for (int i = 0; i < STAT_ENTRIES; i++) begin
        s_valid[i] <= 1'b0;
      end
      upd_seq   <= 64'd0;
      scan_on   <= 1'b0;
      scan_stat <= 1'b0;
      pend      <= 1'b0;
      done_r    <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      cnt       <= '0;
      pidx      <= '0;
      hit_idx   <= '0;
      free_idx  <= '0;
      best_seq  <= '1;
      vict      <= '0;
    end else begin
      if (cfg_we && (cfg_index < CFG_INDEX_W'(NUM_MASKS))) begin
        mask[cfg_index[2:0]] <= cfg_data;
      end
      if (cmd.thr_write) begin
        t_valid[t_waddr] <= 1'b1;
      end
      if (cmd.thr_clear) begin
        t_valid[hit_idx[TIW-1:0]] <= 1'b0;
      end
      if (cmd.stat_create) begin
        s_valid[e_r] <= 1'b1;
      end
      if (s_we) begin
        upd_seq <= upd_seq + 64'd1;
      end

      if (cmd.scan_start) begin
        scan_on   <= 1'b1;
        scan_stat <= cmd.scan_stat;
        pend      <= 1'b0;
        done_r    <= 1'b0;
        hit_r     <= 1'b0;
        free_r    <= 1'b0;
        cnt       <= '0;
        best_seq  <= '1;
        vict      <= '0;
      end else if (scan_on && !done_r) begin
        if (cnt < depth) begin
          cnt  <= cnt + 1'b1;
          pend <= 1'b1;
          pidx <= cnt;
        end else begin
          pend <= 1'b0;
        end
        if (pend) begin
          if (match) begin
            hit_r   <= 1'b1;
            hit_idx <= pidx;
            done_r  <= 1'b1;
          end
          if (!vld_now && !free_r) begin
            free_r   <= 1'b1;
            free_idx <= pidx;
          end
          if (scan_stat && vld_now && (s_rd[328:265] < best_seq)) begin
            best_seq <= s_rd[328:265];
            vict     <= pidx_s;
          end
        end else if (cnt == depth) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  slht_ram #(.WIDTH(THR_RAM_W), .DEPTH(THREAD_ENTRIES)) u_thr_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wdata),
    .rd_addr (cnt[TIW-1:0]),
    .rd_data (t_rd)
  );

  slht_ram #(.WIDTH(STAT_RAM_W), .DEPTH(STAT_ENTRIES)) u_stat_ram (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (e_r),
    .wr_data (s_wdata),
    .rd_addr (cnt[SIW-1:0]),
    .rd_data (s_rd)
  );

  slht_ram #(.WIDTH(64), .DEPTH(HD)) u_hist_ram (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (h_addr),
    .wr_data (h_wdata),
    .rd_addr (h_addr),
    .rd_data (h_rd)
  );

endmodule

[hdl/syscall_latency_histogram_table_unit.sv]
// ----------------------------------------------------------------------------
// syscall_latency_histogram_table_unit
// Per (group, call number) log2 latency histogram of system calls.
// ----------------------------------------------------------------------------
// An event is taken with start while busy is low and its single result comes
// back later on a one-cycle done strobe; the receiver cannot stall, so a
// result must be captured in the cycle that done is high. The block handles
// one event at a time. A tracked enter scans the start table once, one entry
// per cycle; an untracked enter is ignored. A read scans the statistics
// table. An exit scans the start table and, if it finds its start record,
// runs the log2 unit one bit per cycle, scans the statistics table and then
// either updates the entry in a read/modify/write of the histogram memory
// or, for a new entry, clears its histogram row at one bucket per cycle.
// The scans and the histogram sweep are set by the single read port of each
// table. Mask registers are written through cfg_we, cfg_index and cfg_data.
module syscall_latency_histogram_table_unit
  import slht_pkg::*;
#(
  parameter int THREAD_ENTRIES = THREAD_ENTRIES_DEF,
  parameter int STAT_ENTRIES   = STAT_ENTRIES_DEF,
  parameter int HIST_BUCKETS   = HIST_BUCKETS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action,
  input  logic [63:0]            thread_key,
  input  logic [8:0]             call_number,
  input  logic [63:0]            group_key,
  input  logic [63:0]            time_ns,
  input  logic                   failed,
  input  logic [5:0]             read_bucket,
  output logic                   done,
  output logic [3:0]             status,
  output logic [5:0]             bucket,
  output logic [63:0]            call_total,
  output logic [63:0]            error_total,
  output logic [63:0]            latency_total,
  output logic [63:0]            bucket_total
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  // The controller sequences each event; the datapath holds every table.
  slht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .st    (st)
  );

  // The reported bucket is the latched copy, zero unless an exit found its
  // start record.
  slht_dp #(
    .THREAD_ENTRIES (THREAD_ENTRIES),
    .STAT_ENTRIES   (STAT_ENTRIES),
    .HIST_BUCKETS   (HIST_BUCKETS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .thread_key    (thread_key),
    .call_number   (call_number),
    .group_key     (group_key),
    .time_ns       (time_ns),
    .failed        (failed),
    .read_bucket   (read_bucket),
    .cmd           (cmd),
    .st            (st),
    .status        (status),
    .bucket        (bucket),
    .call_total    (call_total),
    .error_total   (error_total),
    .latency_total (latency_total),
    .bucket_total  (bucket_total)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the system call latency histogram table. Queued
// enter, exit and read events are driven in random bursts. A local model of
// the start table and the statistics table predicts every result, and the
// bench compares each done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import slht_pkg::*;

  localparam int NTHR = 64;
  localparam int NSTAT = 64;
  localparam int NBKT = 32;
  localparam int IDLE_CYCLES = 400;

  typedef struct {
    logic [1:0]  action;
    logic [63:0] thread_key;
    logic [8:0]  call_number;
    logic [63:0] group_key;
    logic [63:0] time_ns;
    logic        failed;
    logic [5:0]  read_bucket;
  } event_t;

  typedef struct {
    logic [3:0]  status;
    logic [5:0]  bucket;
    logic [63:0] call_total;
    logic [63:0] error_total;
    logic [63:0] latency_total;
    logic [63:0] bucket_total;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic start = 1'b0;
  logic [1:0] action = '0;
  logic [63:0] thread_key = '0;
  logic [8:0] call_number = '0;
  logic [63:0] group_key = '0;
  logic [63:0] time_ns = '0;
  logic failed = 1'b0;
  logic [5:0] read_bucket = '0;
  logic busy, done;
  logic [3:0] status;
  logic [5:0] bucket;
  logic [63:0] call_total, error_total, latency_total, bucket_total;

  syscall_latency_histogram_table_unit u_dut (.*);

  always #5 clk = ~clk;

  // Local copy of the block state.
  logic [63:0] mask_q [NUM_MASKS];
  logic        thr_valid [NTHR];
  logic [63:0] thr_key [NTHR];
  logic [63:0] thr_time [NTHR];
  logic [8:0]  thr_call [NTHR];
  logic        ent_valid [NSTAT];
  logic [63:0] ent_group [NSTAT];
  logic [8:0]  ent_call [NSTAT];
  logic [63:0] ent_count [NSTAT];
  logic [63:0] ent_errors [NSTAT];
  logic [63:0] ent_latency [NSTAT];
  logic [63:0] ent_hist [NSTAT][NBKT];
  int          ent_rank [NSTAT];

  event_t  pending_events [$];
  answer_t expected_answers [$];
  int      errors = 0;
  int      answers_seen = 0;
  int      status_seen [16];
  bit      hold_sender = 1'b0;

  function automatic int log2_floor(logic [63:0] v);
    int b;
    b = 0;
    while (v > 1) begin
      v = v >> 1;
      b++;
    end
    return (b > NBKT - 1) ? NBKT - 1 : b;
  endfunction

  function automatic void promote(int e, int old_rank);
    for (int i = 0; i < NSTAT; i++)
      if (i != e && ent_valid[i] && ent_rank[i] < old_rank) ent_rank[i]++;
    ent_rank[e] = 0;
  endfunction

  // Works out the answer to one event and advances the local state.
  function automatic answer_t predict_answer(event_t ev);
    answer_t a;
    int t, e, b, best;
    logic [63:0] delta;
    logic [8:0] c;
    a = '{default: '0};
    t = -1;
    e = -1;
    if (ev.action == ACT_ENTER) begin
      if (!mask_q[ev.call_number[8:6]][ev.call_number[5:0]]) begin
        a.status = ST_IGNORED;
        return a;
      end
      for (int i = 0; i < NTHR; i++)
        if (t < 0 && thr_valid[i] && thr_key[i] == ev.thread_key) t = i;
      for (int i = 0; i < NTHR; i++)
        if (t < 0 && !thr_valid[i]) t = i;
      if (t < 0) begin
        a.status = ST_START_DROP;
        return a;
      end
      thr_valid[t] = 1'b1;
      thr_key[t] = ev.thread_key;
      thr_time[t] = ev.time_ns;
      thr_call[t] = ev.call_number;
      a.status = ST_START_KEPT;
    end else if (ev.action == ACT_EXIT) begin
      for (int i = 0; i < NTHR; i++)
        if (t < 0 && thr_valid[i] && thr_key[i] == ev.thread_key) t = i;
      if (t < 0) begin
        a.status = ST_NO_START;
        return a;
      end
      c = thr_call[t];
      delta = ev.time_ns - thr_time[t];
      thr_valid[t] = 1'b0;
      b = log2_floor(delta);
      for (int i = 0; i < NSTAT; i++)
        if (e < 0 && ent_valid[i] && ent_group[i] == ev.group_key && ent_call[i] == c)
          e = i;
      if (e >= 0) begin
        ent_count[e] += 1;
        ent_errors[e] += ev.failed;
        ent_latency[e] += delta;
        ent_hist[e][b] += 1;
        promote(e, ent_rank[e]);
        a.status = ST_UPDATED;
      end else begin
        a.status = ST_CREATED;
        for (int i = 0; i < NSTAT; i++)
          if (e < 0 && !ent_valid[i]) e = i;
        if (e < 0) begin
          // Table full: the least recently updated entry gives way.
          best = 0;
          e = 0;
          for (int i = 0; i < NSTAT; i++)
            if (ent_rank[i] > best) begin
              best = ent_rank[i];
              e = i;
            end
          ent_valid[e] = 1'b0;
          a.status = ST_EVICTED;
        end
        ent_valid[e] = 1'b1;
        ent_group[e] = ev.group_key;
        ent_call[e] = c;
        ent_count[e] = 1;
        ent_errors[e] = ev.failed;
        ent_latency[e] = delta;
        for (int k = 0; k < NBKT; k++) ent_hist[e][k] = '0;
        ent_hist[e][b] = 1;
        promote(e, NSTAT);
      end
      a.bucket = b[5:0];
      a.call_total = ent_count[e];
      a.error_total = ent_errors[e];
      a.latency_total = ent_latency[e];
      a.bucket_total = ent_hist[e][b];
    end else if (ev.action == ACT_READ) begin
      for (int i = 0; i < NSTAT; i++)
        if (e < 0 && ent_valid[i] && ent_group[i] == ev.group_key &&
            ent_call[i] == ev.call_number) e = i;
      if (e < 0) begin
        a.status = ST_READ_MISS;
        return a;
      end
      a.status = ST_READ_HIT;
      a.call_total = ent_count[e];
      a.error_total = ent_errors[e];
      a.latency_total = ent_latency[e];
      if (ev.read_bucket < NBKT) a.bucket_total = ent_hist[e][ev.read_bucket];
    end
    return a;
  endfunction

  // Driver: bursts of transfers separated by random gaps. The local model is
  // advanced at the edge that accepts the transfer.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_answers.push_back(predict_answer(pending_events.pop_front()));
      end
      if (start && busy) begin
        // Keep holding the current transfer.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_events.size() > 0 && !hold_sender &&
                   !(start && !busy && pending_events.size() == 0)) begin
        action <= pending_events[0].action;
        thread_key <= pending_events[0].thread_key;
        call_number <= pending_events[0].call_number;
        group_key <= pending_events[0].group_key;
        time_ns <= pending_events[0].time_ns;
        failed <= pending_events[0].failed;
        read_bucket <= pending_events[0].read_bucket;
        start <= 1'b1;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(12, 0);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(150, 1);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe is one result transfer.
  always @(posedge clk) begin
    answer_t x;
    if (!rst && done) begin
      answers_seen++;
      status_seen[status]++;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        errors++;
      end else begin
        x = expected_answers.pop_front();
        if (status !== x.status) begin
          $display("%0t: status expected %0d got %0d", $time, x.status, status);
          errors++;
        end
        if (bucket !== x.bucket) begin
          $display("%0t: bucket expected %0d got %0d", $time, x.bucket, bucket);
          errors++;
        end
        if (call_total !== x.call_total) begin
          $display("%0t: call_total expected %h got %h", $time, x.call_total, call_total);
          errors++;
        end
        if (error_total !== x.error_total) begin
          $display("%0t: error_total expected %h got %h", $time, x.error_total,
                   error_total);
          errors++;
        end
        if (latency_total !== x.latency_total) begin
          $display("%0t: latency_total expected %h got %h", $time, x.latency_total,
                   latency_total);
          errors++;
        end
        if (bucket_total !== x.bucket_total) begin
          $display("%0t: bucket_total expected %h got %h", $time, x.bucket_total,
                   bucket_total);
          errors++;
        end
      end
    end
  end

  // Builds one event; keys come from small pools so entries get hit again.
  function automatic event_t make_event(logic [1:0] act, int pool);
    event_t ev;
    ev.action = act;
    ev.thread_key = (pool > 0) ? 64'(($urandom_range(pool - 1, 0)) * 64'h0100_0001_0000_0001)
                               : {$urandom, $urandom};
    ev.call_number = (pool > 0) ? 9'($urandom_range(15, 0) * 33) : 9'($urandom);
    ev.group_key = (pool > 0) ? 64'({$urandom_range(3, 0), 60'h0}) |
                                64'($urandom_range(3, 0))
                              : {$urandom, $urandom};
    ev.time_ns = {$urandom, $urandom} >> $urandom_range(63, 0);
    ev.failed = 1'($urandom);
    ev.read_bucket = 6'($urandom);
    return ev;
  endfunction

  task automatic wait_idle();
    // Every transfer of this block yields a result, so an empty queue means idle.
    while (pending_events.size() > 0 || expected_answers.size() > 0 || start)
      @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mask_q[idx] = val;
  endtask

  task automatic push_event(event_t ev);
    pending_events.push_back(ev);
  endtask

  initial begin
    event_t ev;
    int r;
    for (int i = 0; i < NUM_MASKS; i++) mask_q[i] = '0;
    for (int i = 0; i < NTHR; i++) thr_valid[i] = 1'b0;
    for (int i = 0; i < NSTAT; i++) begin
      ent_valid[i] = 1'b0;
      ent_rank[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Masks at reset: every enter is ignored; unknown action and misses too.
    ev = make_event(ACT_ENTER, 0); push_event(ev);
    ev = make_event(ACT_EXIT, 0); push_event(ev);
    ev = make_event(ACT_READ, 0); push_event(ev);
    ev = make_event(2'd3, 0); push_event(ev);
    wait_idle();

    // All calls tracked; directed extremes.
    for (int i = 0; i < NUM_MASKS; i++) write_mask(i, '1);
    ev = make_event(ACT_ENTER, 0);
    ev.thread_key = '1; ev.call_number = 9'h1FF; ev.time_ns = '1; push_event(ev);
    ev.action = ACT_EXIT; ev.group_key = '1; ev.time_ns = '1; push_event(ev);
    ev.action = ACT_ENTER; ev.time_ns = 64'd5; push_event(ev);
    ev.time_ns = 64'd9; push_event(ev);
    // Wrapped elapsed time lands in the top bucket.
    ev.action = ACT_EXIT; ev.time_ns = 64'd3; ev.failed = 1'b1; push_event(ev);
    ev.action = ACT_READ; ev.read_bucket = 6'd31; push_event(ev);
    ev.read_bucket = 6'd63; push_event(ev);
    ev.read_bucket = 6'd0; push_event(ev);
    ev.action = ACT_ENTER; ev.thread_key = '0; ev.call_number = '0; ev.time_ns = '0;
    push_event(ev);
    ev.action = ACT_EXIT; ev.group_key = '0; ev.failed = 1'b0; push_event(ev);
    ev.action = ACT_READ; ev.read_bucket = 6'd0; push_event(ev);
    wait_idle();
    // Fill the start table and overflow it.
    for (int i = 0; i < NTHR + 2; i++) begin
      ev = make_event(ACT_ENTER, 0); ev.thread_key = 64'(i); push_event(ev);
    end
    wait_idle();
    hold_sender = 1'b0;

    // Random phases with different mask settings.
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < NUM_MASKS; i++)
        case (phase)
          0: write_mask(i, '0);
          1: write_mask(i, '1);
          default: write_mask(i, {$urandom, $urandom} | {$urandom, $urandom});
        endcase
      for (int n = 0; n < 300; n++) begin
        r = $urandom_range(99, 0);
        if (r < 40) ev = make_event(ACT_ENTER, 48);
        else if (r < 80) ev = make_event(ACT_EXIT, 48);
        else if (r < 95) ev = make_event(ACT_READ, 48);
        else if (r < 98) ev = make_event(2'($urandom), 0);
        else ev = make_event(ACT_EXIT, 0);
        push_event(ev);
        // Sender pause until the block has drained.
        if (n == 150) begin
          while (pending_events.size() > 0) @(posedge clk);
          hold_sender = 1'b1;
          while (expected_answers.size() > 0 || start) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      wait_idle();
    end
    $display("Results checked: %0d; creations %0d, evictions %0d, read hits %0d, drops %0d.",
             answers_seen, status_seen[ST_CREATED], status_seen[ST_EVICTED],
             status_seen[ST_READ_HIT], status_seen[ST_START_DROP]);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

endmodule
